@@ sv/cdq_pkg.sv @@
package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic fill;
    logic drop;
  } cell_cmd_t;

endpackage

@@ sv/cdq_req_if.sv @@
interface cdq_req_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

@@ sv/cdq_rsp_if.sv @@
interface cdq_rsp_if import cdq_pkg::*; #(
  parameter int COUNT_W = 5
) ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink (input valid, input read_value, input status, input count, output ready);
endinterface

@@ sv/cdq_cell.sv @@
module cdq_cell import cdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_valid,
  input  logic signed [DATA_W-1:0] right_data,
  input  logic                     right_valid,
  output logic signed [DATA_W-1:0] data,
  output logic                     valid,
  output logic                     tail
);

  logic fill_here;
  logic drop_here;

  assign fill_here = cmd.fill && left_valid && !valid;
  assign drop_here = cmd.drop && valid && !right_valid;
  assign tail = valid && !right_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.shift_right) begin
      valid <= left_valid;
    end else if (cmd.shift_left) begin
      valid <= right_valid;
    end else if (fill_here) begin
      valid <= 1'b1;
    end else if (drop_here) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_right) begin
      data <= left_data;
    end else if (cmd.shift_left) begin
      data <= right_data;
    end else if (fill_here) begin
      data <= push_value;
    end
  end

endmodule

@@ sv/circular_deque_core.sv @@
// A result word is registered and presented in the cycle after its request word is accepted.
// One request word per cycle unless the result is held; all cells shift in the same cycle.
// A request is taken whenever the result register is empty or being taken.
// Reset (synchronous, rst high) empties the deque: all cell valid bits and the count clear.
// The front element always sits in the first cell; the back element is the last valid cell.
module circular_deque_core import cdq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_tail;
  cell_cmd_t                cmd;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     rsp_valid;
  logic signed [DATA_W-1:0] rsp_value;
  status_t                  rsp_status;
  logic [CNT_W-1:0]         rsp_count;

  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  logic signed [DATA_W-1:0] back_data;
  logic signed [DATA_W-1:0] rd_next;
  status_t                  st_next;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept = req.valid && req.ready;
  assign is_full = (count == CNT_FULL);
  assign is_empty = (count == '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] l_data;
    logic                     l_valid;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_valid;

    if (i == 0) begin : g_first
      assign l_data = req.value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .push_value  (req.value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .tail        (cell_tail[i])
    );
  end

  // The tail flags are at most one-hot (none when empty), so the back element is an AND-OR select.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | (cell_tail[i] ? cell_data[i] : '0);
    end
  end

  always_comb begin
    cmd = '0;
    rd_next = '0;
    st_next = ST_OK;
    count_next = count;
    unique case (op_t'(req.op)) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (is_full) begin
          st_next = ST_FULL;
        end else begin
          cmd.shift_right = (op_t'(req.op) == OP_PUSH_FRONT);
          cmd.fill = (op_t'(req.op) == OP_PUSH_BACK);
          count_next = count + 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (is_empty) begin
          st_next = ST_EMPTY;
        end else begin
          rd_next = cell_data[0];
          if (op_t'(req.op) == OP_POP_FRONT) begin
            cmd.shift_left = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (is_empty) begin
          st_next = ST_EMPTY;
        end else begin
          rd_next = back_data;
          if (op_t'(req.op) == OP_POP_BACK) begin
            cmd.drop = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_value <= rd_next;
      rsp_status <= st_next;
      rsp_count <= count_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.status = rsp_status;
  assign rsp.count = rsp_count;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("element count above capacity");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_tail) && (cell_valid[0] || !(|cell_valid)))
    else $error("cell valid bits do not form a prefix");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("count disagrees with the cell chain");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !is_full && (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK)
    |=> count == $past(count) + 1'b1)
    else $error("push did not add an element");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    accept && is_empty && (req.op == OP_POP_FRONT || req.op == OP_POP_BACK ||
    req.op == OP_PEEK_FRONT || req.op == OP_PEEK_BACK)
    |=> rsp_status == ST_EMPTY && rsp_value == '0)
    else $error("empty deque did not report empty");

endmodule
